// ===== design/command_dequeue_byte_fifo_defines.svh =====
// assertion macros shared by the byte fifo rtl
// no dependencies; clock and reset are the project's standard names
`ifndef COMMAND_DEQUEUE_BYTE_FIFO_DEFINES_SVH
`define COMMAND_DEQUEUE_BYTE_FIFO_DEFINES_SVH

// same-cycle implication
`define CDBF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CDBF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/cdbf_pkg.sv =====
// shared types, constants and message text for the byte fifo
// no dependencies
`default_nettype none

package cdbf_pkg;

   localparam int DEPTH_DEFAULT = 64;

   localparam logic [7:0] CMD_DEQUEUE = 8'd13;

   localparam int MSG_IDX_W = 4;
   localparam logic [MSG_IDX_W-1:0] MSG_FULL_LAST  = 4'd12;
   localparam logic [MSG_IDX_W-1:0] MSG_EMPTY_LAST = 4'd13;

   // padded to a power of two so a message index never falls off the end
   localparam logic [7:0] MSG_FULL_TEXT [16] = '{
      8'h42, 8'h55, 8'h46, 8'h46, 8'h45, 8'h52, 8'h20, 8'h46,
      8'h55, 8'h4C, 8'h4C, 8'h0A, 8'h0D, 8'h00, 8'h00, 8'h00
   };
   localparam logic [7:0] MSG_EMPTY_TEXT [16] = '{
      8'h42, 8'h55, 8'h46, 8'h46, 8'h45, 8'h52, 8'h20, 8'h45,
      8'h4D, 8'h50, 8'h54, 8'h59, 8'h0A, 8'h0D, 8'h00, 8'h00
   };

   typedef struct packed {
      logic launch;
      logic is_full;
   } msg_req_type;

endpackage

`default_nettype wire

// ===== design/cdbf_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`default_nettype none

module cdbf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/cdbf_ctrl.sv =====
// request decode, ring pointers and fill count for the byte fifo
// uses cdbf_pkg
`default_nettype none

module cdbf_ctrl #(
   parameter int DEPTH = cdbf_pkg::DEPTH_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     accept,
   input  wire logic [7:0]               rx_byte,
   output logic                          ram_wr_en,
   output logic      [$clog2(DEPTH)-1:0] ram_wr_addr,
   output logic                          ram_rd_en,
   output logic      [$clog2(DEPTH)-1:0] ram_rd_addr,
   output logic                          deq_valid,
   output cdbf_pkg::msg_req_type         msg_req
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [AW-1:0] rd_pos_ff, rd_pos_in;
   logic [AW-1:0] wr_pos_ff, wr_pos_in;
   logic [CW-1:0] count_ff, count_in;
   logic          deq_valid_ff;
   logic          is_cmd, empty, full, do_deq, do_store;

   assign is_cmd   = (rx_byte == cdbf_pkg::CMD_DEQUEUE);
   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CW'(DEPTH));
   assign do_deq   = accept && is_cmd && !empty;
   assign do_store = accept && !is_cmd && !full;

   always_comb begin
      rd_pos_in = rd_pos_ff;
      wr_pos_in = wr_pos_ff;
      count_in  = count_ff;
      if (do_deq) begin
         rd_pos_in = (rd_pos_ff == AW'(DEPTH - 1)) ? '0 : rd_pos_ff + AW'(1);
         count_in  = count_ff - CW'(1);
      end else if (do_store) begin
         wr_pos_in = (wr_pos_ff == AW'(DEPTH - 1)) ? '0 : wr_pos_ff + AW'(1);
         count_in  = count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pos_ff    <= '0;
         wr_pos_ff    <= '0;
         count_ff     <= '0;
         deq_valid_ff <= 1'b0;
      end else begin
         rd_pos_ff    <= rd_pos_in;
         wr_pos_ff    <= wr_pos_in;
         count_ff     <= count_in;
         deq_valid_ff <= do_deq;
      end
   end

   assign ram_wr_en       = do_store;
   assign ram_wr_addr     = wr_pos_ff;
   assign ram_rd_en       = do_deq;
   assign ram_rd_addr     = rd_pos_ff;
   assign deq_valid       = deq_valid_ff;
   assign msg_req.launch  = accept && (is_cmd ? empty : full);
   assign msg_req.is_full = !is_cmd;

endmodule

`default_nettype wire

// ===== design/cdbf_msg.sv =====
// message sequencer: plays out the full or empty text one byte a cycle
// uses cdbf_pkg
`default_nettype none

module cdbf_msg (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cdbf_pkg::msg_req_type msg_req,
   output logic                       busy,
   output logic                       out_valid,
   output logic [7:0]                 out_byte,
   output logic                       out_end
);

   logic                          active_ff, active_in;
   logic                          is_full_ff, is_full_in;
   logic [cdbf_pkg::MSG_IDX_W-1:0] idx_ff, idx_in;
   logic                          out_valid_ff;
   logic [7:0]                    out_byte_ff, out_byte_in;
   logic                          out_end_ff;
   logic                          last;

   assign last = (idx_ff == (is_full_ff ? cdbf_pkg::MSG_FULL_LAST
                                        : cdbf_pkg::MSG_EMPTY_LAST));

   always_comb begin
      active_in   = active_ff;
      is_full_in  = is_full_ff;
      idx_in      = idx_ff;
      out_byte_in = is_full_ff ? cdbf_pkg::MSG_FULL_TEXT[idx_ff]
                               : cdbf_pkg::MSG_EMPTY_TEXT[idx_ff];
      if (active_ff) begin
         idx_in = idx_ff + cdbf_pkg::MSG_IDX_W'(1);
         if (last) begin
            active_in = 1'b0;
         end
      end else if (msg_req.launch) begin
         active_in  = 1'b1;
         is_full_in = msg_req.is_full;
         idx_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
         out_end_ff   <= 1'b0;
      end else begin
         active_ff    <= active_in;
         out_valid_ff <= active_ff;
         out_end_ff   <= active_ff && last;
      end
      is_full_ff  <= is_full_in;
      idx_ff      <= idx_in;
      out_byte_ff <= out_byte_in;
   end

   assign busy      = active_ff;
   assign out_valid = out_valid_ff;
   assign out_byte  = out_byte_ff;
   assign out_end   = out_end_ff;

endmodule

`default_nettype wire

// ===== design/command_dequeue_byte_fifo.sv =====
// Byte fifo driven by received bytes. A request is taken at a clock edge with start high and
// busy low. Any byte but carriage return is stored (no response) and a carriage return pops
// the oldest byte, which appears on the response ports, strobed, in the cycle after the
// request; stores and pops can be taken every cycle while busy is low. A byte arriving at a
// full ring or a carriage return at an empty one plays out "BUFFER FULL\n\r" (13 bytes) or
// "BUFFER EMPTY\n\r" (14 bytes) from the message sequencer, one byte a cycle, registered
// through active_ff and then the output byte register; busy stays high while it runs.
// rsp_run_end marks the last byte of every response. The receiver cannot stall: each strobe
// is one cycle only. Uses cdbf_pkg, cdbf_ram, cdbf_ctrl, cdbf_msg and the defines header.
`default_nettype none
`include "command_dequeue_byte_fifo_defines.svh"

module command_dequeue_byte_fifo #(
   parameter int DEPTH = cdbf_pkg::DEPTH_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_strobe,
   output logic      [7:0] rsp_tx_byte,
   output logic            rsp_run_end
);

   localparam int AW = $clog2(DEPTH);

   logic                  accept;
   logic                  ram_wr_en, ram_rd_en;
   logic [AW-1:0]         ram_wr_addr, ram_rd_addr;
   logic [7:0]            ram_rd_data;
   logic                  deq_valid;
   cdbf_pkg::msg_req_type msg_req;
   logic                  msg_busy, msg_valid, msg_end;
   logic [7:0]            msg_byte;

   assign accept = start && !busy;

   cdbf_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .rx_byte     (req_rx_byte),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .deq_valid   (deq_valid),
      .msg_req     (msg_req)
   );

   cdbf_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_rx_byte),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   cdbf_msg u_msg (
      .clock     (clock),
      .reset     (reset),
      .msg_req   (msg_req),
      .busy      (msg_busy),
      .out_valid (msg_valid),
      .out_byte  (msg_byte),
      .out_end   (msg_end)
   );

   assign busy        = msg_busy;
   assign rsp_strobe  = deq_valid || msg_valid;
   assign rsp_tx_byte = deq_valid ? ram_rd_data : msg_byte;
   assign rsp_run_end = deq_valid || msg_end;

   // pop data and message text must never collide on the response ports
   `CDBF_ASSERT_NOW(a_no_collision, deq_valid, !msg_valid, "pop and message overlap")
   // a store or pop never starts the message sequencer
   `CDBF_ASSERT_NEXT(a_plain_no_busy, accept && !msg_req.launch, !busy,
                     "busy raised by store or pop")
   // a full or empty request always starts the sequencer
   `CDBF_ASSERT_NEXT(a_launch_busy, msg_req.launch, busy, "message not started")
   // the message sequencer is never asked to start while already running
   `CDBF_ASSERT_NOW(a_launch_idle, msg_req.launch, !msg_busy, "launch while busy")

endmodule

`default_nettype wire
